/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define DLSP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: port check failed");

// Same, with a message of the caller's choosing.
`define DLSP_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

/* rtl/dlsp_pkg.sv */
// Shared types and constants for the dive log sample parser.
// No dependencies.
package dlsp_pkg;

    localparam int unsigned MAX_RECORD_BYTES_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH_DEF      = 4;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned TIME_W   = 20;
    localparam int unsigned DEPTH_W  = 10;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned VLEN_W   = 2;
    localparam int unsigned WARN_W   = 6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VENDOR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

    // model classes
    localparam logic [1:0] CLASS_OTHER  = 2'd0;
    localparam logic [1:0] CLASS_NITROX = 2'd1;
    localparam logic [1:0] CLASS_OXYGEN = 2'd2;

    localparam logic [BYTE_W-1:0] ID_NIBBLE_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] ID_NITROX      = 8'hF0;
    localparam logic [BYTE_W-1:0] ID_OXYGEN      = 8'hA0;

    // header layout
    localparam int unsigned CLASS_BYTE_POS   = 3;
    localparam int unsigned SAMPLE_START     = 22 + 18;
    localparam int unsigned NITROX_EXTRA     = 2;
    localparam int unsigned OXYGEN_EXTRA     = 3;
    localparam int unsigned MIN_RECORD_BYTES = 18;

    localparam logic [TIME_W-1:0] TIME_STEP      = 20'd20;
    localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_SAT_LIMIT = TIME_MAX - TIME_STEP;

    // one bit per result a transaction may cause, in delivery order
    localparam int unsigned MASK_W      = 9;
    localparam int unsigned MASK_SAMPLE = 0;
    localparam int unsigned MASK_EVENT0 = 1;
    localparam int unsigned MASK_VENDOR = 7;
    localparam int unsigned MASK_END    = 8;

    localparam logic [VLEN_W-1:0] VLEN_DECO_ONLY = 2'd1;
    localparam logic [VLEN_W-1:0] VLEN_DECO_OXY  = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [TIME_W-1:0]  time_seconds;
        logic [DEPTH_W-1:0] depth_raw;
        logic [BYTE_W-1:0]  deco_info;
        logic [BYTE_W-1:0]  oxygen_info;
        logic [VLEN_W-1:0]  vendor_length;
        logic               record_status;
    } t_bundle;

endpackage

/* rtl/dlsp_parser.sv */
// Input register and per-byte parse logic; emits one result bundle for each byte that causes a result.
// Depends on dlsp_pkg.
module dlsp_parser import dlsp_pkg::*; #(
    parameter int unsigned MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic              i_last_byte,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_full,
    output logic              o_push,
    output t_bundle           o_bundle
);

    localparam int unsigned PW = $clog2(MAX_RECORD_BYTES + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_RECORD_BYTES);

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_DECO = 2'd2;
    localparam logic [1:0] PH_OXY  = 2'd3;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [PW-1:0]     r_pos,   n_pos;
    logic [1:0]        r_class, n_class;
    logic [TIME_W-1:0] r_time,  n_time;
    logic [1:0]        r_mod3,  n_mod3;
    logic [1:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_held_high, n_held_high;
    logic [BYTE_W-1:0] r_held_deco, n_held_deco;

    logic       w_move;
    logic [5:0] w_start;
    logic       w_in_area;
    t_bundle    w_bundle;

    assign w_move     = r_in_valid && !i_full;
    assign o_in_ready = !r_in_valid || !i_full;

    always_comb begin
        n_class     = r_class;
        n_pos       = r_pos;
        n_time      = r_time;
        n_mod3      = r_mod3;
        n_phase     = r_phase;
        n_held_high = r_held_high;
        n_held_deco = r_held_deco;
        w_bundle    = '0;

        if (r_pos == PW'(CLASS_BYTE_POS)) begin
            if ((r_byte & ID_NIBBLE_MASK) == ID_NITROX) begin
                n_class = CLASS_NITROX;
            end else if ((r_byte & ID_NIBBLE_MASK) == ID_OXYGEN) begin
                n_class = CLASS_OXYGEN;
            end else begin
                n_class = CLASS_OTHER;
            end
        end

        case (n_class)
            CLASS_NITROX: w_start = 6'(SAMPLE_START + NITROX_EXTRA);
            CLASS_OXYGEN: w_start = 6'(SAMPLE_START + OXYGEN_EXTRA);
            default:      w_start = 6'(SAMPLE_START);
        endcase
        w_in_area = r_pos >= PW'(w_start);

        if (w_in_area) begin
            case (r_phase)
                PH_HIGH: begin
                    n_held_high = r_byte;
                    n_phase     = PH_LOW;
                end
                PH_LOW: begin
                    w_bundle.mask[MASK_SAMPLE] = 1'b1;
                    w_bundle.mask[MASK_EVENT0 +: WARN_W] = r_byte[WARN_W-1:0];
                    w_bundle.time_seconds = r_time;
                    w_bundle.depth_raw = {r_held_high, r_byte[BYTE_W-1:WARN_W]};
                    // a multiple of 60 s is every third sample until saturation
                    n_phase = (r_mod3 == 2'd2 && r_time != TIME_MAX) ? PH_DECO : PH_HIGH;
                    n_mod3  = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                    n_time  = (r_time >= TIME_SAT_LIMIT) ? TIME_MAX : r_time + TIME_STEP;
                end
                PH_DECO: begin
                    if (n_class == CLASS_OXYGEN) begin
                        n_held_deco = r_byte;
                        n_phase     = PH_OXY;
                    end else begin
                        w_bundle.mask[MASK_VENDOR] = 1'b1;
                        w_bundle.deco_info     = r_byte;
                        w_bundle.vendor_length = VLEN_DECO_ONLY;
                        n_phase = PH_HIGH;
                    end
                end
                default: begin
                    w_bundle.mask[MASK_VENDOR] = 1'b1;
                    w_bundle.deco_info     = r_held_deco;
                    w_bundle.oxygen_info   = r_byte;
                    w_bundle.vendor_length = VLEN_DECO_OXY;
                    n_phase = PH_HIGH;
                end
            endcase
        end

        if (r_pos < POS_MAX) begin
            n_pos = r_pos + PW'(1);
        end

        if (r_last) begin
            w_bundle.mask[MASK_END] = 1'b1;
            // short record or vendor bytes still owed
            w_bundle.record_status = (r_pos < PW'(MIN_RECORD_BYTES - 1)) || n_phase[1];
        end
    end

    assign o_push   = w_move && (w_bundle.mask != '0);
    assign o_bundle = w_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_class <= CLASS_OTHER;
            r_time  <= TIME_STEP;
            r_mod3  <= 2'd0;
            r_phase <= PH_HIGH;
        end else if (w_move) begin
            if (r_last) begin
                r_pos   <= '0;
                r_class <= CLASS_OTHER;
                r_time  <= TIME_STEP;
                r_mod3  <= 2'd0;
                r_phase <= PH_HIGH;
            end else begin
                r_pos   <= n_pos;
                r_class <= n_class;
                r_time  <= n_time;
                r_mod3  <= n_mod3;
                r_phase <= n_phase;
            end
        end
    end

    // held bytes are always written before they are read
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_held_high <= n_held_high;
            r_held_deco <= n_held_deco;
        end
    end

endmodule

/* rtl/dlsp_queue.sv */
// Small register queue of result bundles between parser and output stage.
// Depends on dlsp_pkg.
module dlsp_queue import dlsp_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_full,
    output logic    o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_bundle       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/dlsp_serializer.sv */
// Output stage: walks the head bundle one result per transaction.
// Depends on dlsp_pkg.
module dlsp_serializer import dlsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_bundle            i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [KIND_W-1:0]  o_kind,
    output logic [TIME_W-1:0]  o_time_seconds,
    output logic [DEPTH_W-1:0] o_depth_raw,
    output logic [EVENT_W-1:0] o_event_code,
    output logic [BYTE_W-1:0]  o_deco_info,
    output logic [BYTE_W-1:0]  o_oxygen_info,
    output logic [VLEN_W-1:0]  o_vendor_length,
    output logic               o_record_status,
    output logic               o_last_result
);

    logic               r_valid;
    logic               r_started;
    logic [MASK_W-1:0]  r_pend;
    logic [KIND_W-1:0]  r_kind;
    logic [TIME_W-1:0]  r_time;
    logic [DEPTH_W-1:0] r_depth;
    logic [EVENT_W-1:0] r_event;
    logic [BYTE_W-1:0]  r_deco;
    logic [BYTE_W-1:0]  r_oxy;
    logic [VLEN_W-1:0]  r_vlen;
    logic               r_status;
    logic               r_last;

    logic               w_load;
    logic [MASK_W-1:0]  w_cur, w_low, w_rest;
    logic [EVENT_W-1:0] w_event;

    assign w_load = !i_empty && (!r_valid || i_out_ready);
    assign w_cur  = r_started ? r_pend : i_head.mask;
    assign w_low  = w_cur & (~w_cur + MASK_W'(1));
    assign w_rest = w_cur & ~w_low;
    assign o_pop  = w_load && (w_rest == '0);

    always_comb begin
        w_event = '0;
        for (int i = 0; i < WARN_W; i++) begin
            if (w_low[MASK_EVENT0 + i]) begin
                w_event = EVENT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid   <= 1'b1;
                r_started <= w_rest != '0;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pend   <= w_rest;
            r_last   <= w_rest == '0;
            r_time   <= '0;
            r_depth  <= '0;
            r_event  <= '0;
            r_deco   <= '0;
            r_oxy    <= '0;
            r_vlen   <= '0;
            r_status <= 1'b0;
            if (w_low[MASK_SAMPLE]) begin
                r_kind  <= KIND_SAMPLE;
                r_time  <= i_head.time_seconds;
                r_depth <= i_head.depth_raw;
            end else if (w_low[MASK_VENDOR]) begin
                r_kind <= KIND_VENDOR;
                r_deco <= i_head.deco_info;
                r_oxy  <= i_head.oxygen_info;
                r_vlen <= i_head.vendor_length;
            end else if (w_low[MASK_END]) begin
                r_kind   <= KIND_END;
                r_status <= i_head.record_status;
            end else begin
                r_kind  <= KIND_EVENT;
                r_time  <= i_head.time_seconds;
                r_event <= w_event;
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_kind          = r_kind;
    assign o_time_seconds  = r_time;
    assign o_depth_raw     = r_depth;
    assign o_event_code    = r_event;
    assign o_deco_info     = r_deco;
    assign o_oxygen_info   = r_oxy;
    assign o_vendor_length = r_vlen;
    assign o_record_status = r_status;
    assign o_last_result   = r_last;

endmodule

/* rtl/dive_log_sample_parser.sv */
// Top level of the dive log sample parser.
// Depends on dlsp_pkg, dlsp_parser, dlsp_queue and dlsp_serializer.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one record byte per
//    transaction, i_last_byte marking the final byte of a record.
//  - Output channel (o_out_valid / i_out_ready) carries one result per
//    transaction: sample, warning event, vendor info or end of record.
//    o_last_result flags the final result caused by one input byte.
//  - Path: a byte sits in the input register, is parsed into a bundle and
//    queued; its first result then leaves through the output register.
//  - Throughput: one byte per cycle while the bundle queue has room; the
//    output register hands out one result per cycle while i_out_ready is
//    high, so a sample with n warning bits set yields 1 + n results. The queue
//    (QUEUE_DEPTH bundles) absorbs such bursts; when it fills, o_in_ready
//    drops until the output side drains.
//  - Receiver stall: the output register holds its result while i_out_ready
//    is low; the parser keeps taking bytes until the queue is full.
//  - Reset (synchronous, active low) empties every stage and returns the
//    parse state to the start of a record; no clearing pass is needed.
//  - The last byte of a record also resets the parse state, so the next
//    byte opens a new record.
module dive_log_sample_parser import dlsp_pkg::*; #(
    parameter int unsigned MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [BYTE_W-1:0]  i_byte_value,
    input  logic               i_last_byte,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [KIND_W-1:0]  o_kind,
    output logic [TIME_W-1:0]  o_time_seconds,
    output logic [DEPTH_W-1:0] o_depth_raw,
    output logic [EVENT_W-1:0] o_event_code,
    output logic [BYTE_W-1:0]  o_deco_info,
    output logic [BYTE_W-1:0]  o_oxygen_info,
    output logic [VLEN_W-1:0]  o_vendor_length,
    output logic               o_record_status,
    output logic               o_last_result
);

    // parser -> queue
    logic    w_push;
    t_bundle w_bundle;
    // queue -> output stage
    logic    w_full;
    logic    w_empty;
    logic    w_pop;
    t_bundle w_head;

    // Input register plus combinational parse; all record state lives here.
    dlsp_parser #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_bundle     (w_bundle)
    );

    // Bytes that cause no result (high sample bytes, header) are not queued.
    dlsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_bundle),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Delivery order inside a bundle: sample, events from bit 0 up,
    // vendor info, end of record.
    dlsp_serializer u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_time_seconds  (o_time_seconds),
        .o_depth_raw     (o_depth_raw),
        .o_event_code    (o_event_code),
        .o_deco_info     (o_deco_info),
        .o_oxygen_info   (o_oxygen_info),
        .o_vendor_length (o_vendor_length),
        .o_record_status (o_record_status),
        .o_last_result   (o_last_result)
    );

endmodule

/* rtl/dlsp_checker.sv */
// Port-level checks for the dive log sample parser, bound to the top level.
// Depends on dlsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlsp_checker import dlsp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [KIND_W-1:0]  o_kind,
    input logic [TIME_W-1:0]  o_time_seconds,
    input logic [DEPTH_W-1:0] o_depth_raw,
    input logic [VLEN_W-1:0]  o_vendor_length,
    input logic               o_last_result
);

    logic w_is_end;
    logic w_untimed;
    logic w_no_time;
    logic w_vlen_ok;

    assign w_is_end  = o_out_valid && (o_kind == KIND_END);
    assign w_untimed = o_out_valid && (o_kind == KIND_VENDOR || o_kind == KIND_END);
    assign w_no_time = (o_time_seconds == '0) && (o_depth_raw == '0);
    assign w_vlen_ok = (o_vendor_length == VLEN_DECO_ONLY) ||
                       (o_vendor_length == VLEN_DECO_OXY);

    // stalled result stays offered, its kind unchanged
    `DLSP_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind))

    // end of record always closes the results of its byte
    `DLSP_ASSERT_MSG(a_end_last, w_is_end |-> o_last_result, "end result without last mark")

    // vendor and end results carry no time or depth
    `DLSP_ASSERT(a_no_time, w_untimed |-> w_no_time)

    // vendor length is only ever one or two on vendor results
    `DLSP_ASSERT_MSG(a_vlen, o_out_valid && o_kind == KIND_VENDOR |-> w_vlen_ok, "bad vendor length")

endmodule

bind dive_log_sample_parser dlsp_checker u_dlsp_checker (.*);
